FILE: design/usi_pkg.sv
`default_nettype none

package usi_pkg;

  // Pipeline depth: input register through output register
  localparam int NumStages = 8;

  localparam int ScaleW   = 5;
  localparam int SampleW  = 8;
  localparam int PosW     = 16;
  localparam int CfgDataW = 5;

  // Reciprocal scaling for the division by scale and by 2*scale^3
  localparam int LinShift = 20;
  localparam int DenShift = 27;
  localparam int LinOne   = 1 << LinShift;
  localparam int CubOne   = 1 << (DenShift - 1);

  typedef enum logic [0:0] {
    CfgScale = 1'b0,
    CfgMode  = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    ModeLinear = 1'b0,
    ModeCubic  = 1'b1
  } mode_e;

  localparam logic [ScaleW-1:0] ScaleRst = 5'd2;
  localparam mode_e             ModeRst  = ModeCubic;

  // floor(2^20 / s); a scale of zero behaves as one
  localparam logic [20:0] RecipLin [32] = '{
    21'(LinOne),      21'(LinOne),      21'(LinOne / 2),  21'(LinOne / 3),
    21'(LinOne / 4),  21'(LinOne / 5),  21'(LinOne / 6),  21'(LinOne / 7),
    21'(LinOne / 8),  21'(LinOne / 9),  21'(LinOne / 10), 21'(LinOne / 11),
    21'(LinOne / 12), 21'(LinOne / 13), 21'(LinOne / 14), 21'(LinOne / 15),
    21'(LinOne / 16), 21'(LinOne / 17), 21'(LinOne / 18), 21'(LinOne / 19),
    21'(LinOne / 20), 21'(LinOne / 21), 21'(LinOne / 22), 21'(LinOne / 23),
    21'(LinOne / 24), 21'(LinOne / 25), 21'(LinOne / 26), 21'(LinOne / 27),
    21'(LinOne / 28), 21'(LinOne / 29), 21'(LinOne / 30), 21'(LinOne / 31)
  };

  // floor(2^27 / (2*s^3))
  localparam logic [26:0] RecipCub [32] = '{
    27'(CubOne),         27'(CubOne),         27'(CubOne / 8),     27'(CubOne / 27),
    27'(CubOne / 64),    27'(CubOne / 125),   27'(CubOne / 216),   27'(CubOne / 343),
    27'(CubOne / 512),   27'(CubOne / 729),   27'(CubOne / 1000),  27'(CubOne / 1331),
    27'(CubOne / 1728),  27'(CubOne / 2197),  27'(CubOne / 2744),  27'(CubOne / 3375),
    27'(CubOne / 4096),  27'(CubOne / 4913),  27'(CubOne / 5832),  27'(CubOne / 6859),
    27'(CubOne / 8000),  27'(CubOne / 9261),  27'(CubOne / 10648), 27'(CubOne / 12167),
    27'(CubOne / 13824), 27'(CubOne / 15625), 27'(CubOne / 17576), 27'(CubOne / 19683),
    27'(CubOne / 21952), 27'(CubOne / 24389), 27'(CubOne / 27000), 27'(CubOne / 29791)
  };

  typedef logic [9:0]  sq_tab_t  [32];
  typedef logic [15:0] den_tab_t [32];

  function automatic sq_tab_t build_sq();
    sq_tab_t t;
    for (int i = 0; i < 32; i++) begin
      t[i] = (i == 0) ? 10'd1 : 10'(i * i);
    end
    return t;
  endfunction

  function automatic den_tab_t build_den();
    den_tab_t t;
    for (int i = 0; i < 32; i++) begin
      t[i] = (i == 0) ? 16'd2 : 16'(2 * i * i * i);
    end
    return t;
  endfunction

  // s^2 and 2*s^3 per scale
  localparam sq_tab_t  ScaleSq = build_sq();
  localparam den_tab_t CubeDen = build_den();

endpackage

`default_nettype wire

FILE: design/upscale_sample_interpolator.sv
// Eight register stages: a result is offered once its input transaction has passed all of them.
// Throughput is one transaction per cycle while the output accepts; the stage valid bits advance on a ready
// chain, so bubbles collapse and a stalled output holds the pipe without loss.
// Reset (async, active low) clears all stage valid bits and sets scale to 2 and
// mode to cubic; the datapath registers are not reset.
`default_nettype none

module upscale_sample_interpolator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [4:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] position_i,
  input  wire logic [7:0]  far_left_i,
  input  wire logic [7:0]  left_sample_i,
  input  wire logic [7:0]  right_sample_i,
  input  wire logic [7:0]  far_right_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       pixel_value_o
);

  localparam int NS = usi_pkg::NumStages;

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [4:0]     scale_q;
  usi_pkg::mode_e mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= usi_pkg::ScaleRst;
      mode_q  <= usi_pkg::ModeRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (usi_pkg::cfg_idx_e'(cfg_index_i))
        usi_pkg::CfgScale: scale_q <= cfg_data_i;
        usi_pkg::CfgMode:  mode_q  <= usi_pkg::mode_e'(cfg_data_i[0]);
        default:           scale_q <= scale_q;
      endcase
    end
  end

  // Effective scale and its table entries
  logic [4:0]         se;
  logic signed [5:0]  se_s;
  logic [20:0]        rcp_lin;
  logic [26:0]        rcp_cub;
  logic [9:0]         sq;
  logic [15:0]        den;

  assign se      = (scale_q == 5'd0) ? 5'd1 : scale_q;
  assign se_s    = signed'({1'b0, se});
  assign rcp_lin = usi_pkg::RecipLin[se];
  assign rcp_cub = usi_pkg::RecipCub[se];
  assign sq      = usi_pkg::ScaleSq[se];
  assign den     = usi_pkg::CubeDen[se];

  // ---------------------------------------------------------------
  // Pipeline flow control
  // ---------------------------------------------------------------
  logic [NS:1]   vld_q;
  logic [NS:1]   vld_in;
  logic [NS+1:1] rdy;
  logic [NS:1]   en;

  always_comb begin
    rdy[NS+1] = out_ready_i;
    for (int k = NS; k >= 1; k--) begin
      rdy[k] = ~vld_q[k] | rdy[k+1];
    end
  end

  assign vld_in = {vld_q[NS-1:1], in_valid_i};
  assign en     = rdy[NS:1] & vld_in;

  // Advance valid bits wherever the next stage can take them
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  assign in_ready_o  = rdy[1];
  assign out_valid_o = vld_q[NS];

  // ---------------------------------------------------------------
  // Stage 1: capture the input transaction
  // ---------------------------------------------------------------
  logic [15:0] s1_pos_q;
  logic [7:0]  s1_p_q, s1_l_q, s1_r_q, s1_q_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_pos_q <= position_i;
      s1_p_q   <= far_left_i;
      s1_l_q   <= left_sample_i;
      s1_r_q   <= right_sample_i;
      s1_q_q   <= far_right_i;
    end
  end

  // ---------------------------------------------------------------
  // Stage 2: quotient estimate of position / scale, spline coefficients
  // ---------------------------------------------------------------
  logic [36:0]        mod_prod;
  logic signed [12:0] p_x, l_x, r_x, q_x, a_full, b_full, c_full, lr_x;
  logic [15:0]        s2_pos_d, s2_qe_d;
  logic signed [8:0]  s2_a_d;
  logic signed [11:0] s2_b_d;
  logic signed [10:0] s2_c_d;

  assign mod_prod = 37'(s1_pos_q) * 37'(rcp_lin);
  assign s2_qe_d  = mod_prod[usi_pkg::LinShift +: 16];
  assign s2_pos_d = s1_pos_q;

  assign p_x    = signed'({5'b0, s1_p_q});
  assign l_x    = signed'({5'b0, s1_l_q});
  assign r_x    = signed'({5'b0, s1_r_q});
  assign q_x    = signed'({5'b0, s1_q_q});
  assign lr_x   = l_x - r_x;
  assign a_full = r_x - p_x;
  assign b_full = (p_x <<< 1) - ((l_x <<< 2) + l_x) + (r_x <<< 2) - q_x;
  assign c_full = (lr_x <<< 1) + lr_x + q_x - p_x;
  assign s2_a_d = signed'(a_full[8:0]);
  assign s2_b_d = signed'(b_full[11:0]);
  assign s2_c_d = signed'(c_full[10:0]);

  logic [15:0]        s2_pos_q, s2_qe_q;
  logic [7:0]         s2_l_q, s2_r_q;
  logic signed [8:0]  s2_a_q;
  logic signed [11:0] s2_b_q;
  logic signed [10:0] s2_c_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_pos_q <= s2_pos_d;
      s2_qe_q  <= s2_qe_d;
      s2_l_q   <= s1_l_q;
      s2_r_q   <= s1_r_q;
      s2_a_q   <= s2_a_d;
      s2_b_q   <= s2_b_d;
      s2_c_q   <= s2_c_d;
    end
  end

  // ---------------------------------------------------------------
  // Stage 3: correct the remainder to get the phase
  // ---------------------------------------------------------------
  logic [20:0] mod_mul;
  logic [15:0] mod_rem;
  logic [5:0]  mod_rem6;
  logic [4:0]  s3_f_d;

  assign mod_mul  = 21'(s2_qe_q) * 21'(se);
  assign mod_rem  = s2_pos_q - mod_mul[15:0];
  assign mod_rem6 = mod_rem[5:0];
  assign s3_f_d   = (mod_rem6 >= {1'b0, se}) ? 5'(mod_rem6 - {1'b0, se}) : mod_rem6[4:0];

  logic [4:0]         s3_f_q;
  logic [7:0]         s3_l_q, s3_r_q;
  logic signed [8:0]  s3_a_q;
  logic signed [11:0] s3_b_q;
  logic signed [10:0] s3_c_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_f_q <= s3_f_d;
      s3_l_q <= s2_l_q;
      s3_r_q <= s2_r_q;
      s3_a_q <= s2_a_q;
      s3_b_q <= s2_b_q;
      s3_c_q <= s2_c_q;
    end
  end

  // ---------------------------------------------------------------
  // Stage 4: linear numerator, innermost Horner term s*b + f*c
  // ---------------------------------------------------------------
  logic signed [5:0]  f3_s;
  logic [12:0]        s4_num_d;
  logic signed [17:0] s4_u_d;

  assign f3_s     = signed'({1'b0, s3_f_q});
  assign s4_num_d = 13'(se - s3_f_q) * 13'(s3_l_q) + 13'(s3_f_q) * 13'(s3_r_q);
  assign s4_u_d   = 18'(s3_b_q) * 18'(se_s) + 18'(s3_c_q) * 18'(f3_s);

  logic [12:0]        s4_num_q;
  logic signed [17:0] s4_u_q;
  logic [4:0]         s4_f_q;
  logic [7:0]         s4_l_q;
  logic signed [8:0]  s4_a_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s4_num_q <= s4_num_d;
      s4_u_q   <= s4_u_d;
      s4_f_q   <= s3_f_q;
      s4_l_q   <= s3_l_q;
      s4_a_q   <= s3_a_q;
    end
  end

  // ---------------------------------------------------------------
  // Stage 5: linear quotient estimate, middle term s^2*a + f*u
  // ---------------------------------------------------------------
  logic [33:0]        lin_prod;
  logic [7:0]         s5_qe_d;
  logic signed [5:0]  f4_s;
  logic signed [10:0] sq_s;
  logic signed [22:0] s5_v_d;

  assign lin_prod = 34'(s4_num_q) * 34'(rcp_lin);
  assign s5_qe_d  = lin_prod[usi_pkg::LinShift +: 8];
  assign f4_s     = signed'({1'b0, s4_f_q});
  assign sq_s     = signed'({1'b0, sq});
  assign s5_v_d   = 23'(sq_s) * 23'(s4_a_q) + 23'(f4_s) * 23'(s4_u_q);

  logic [12:0]        s5_num_q;
  logic [7:0]         s5_qe_q;
  logic signed [22:0] s5_v_q;
  logic [4:0]         s5_f_q;
  logic [7:0]         s5_l_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s5_num_q <= s4_num_q;
      s5_qe_q  <= s5_qe_d;
      s5_v_q   <= s5_v_d;
      s5_f_q   <= s4_f_q;
      s5_l_q   <= s4_l_q;
    end
  end

  // ---------------------------------------------------------------
  // Stage 6: finish linear quotient, full cubic numerator
  // ---------------------------------------------------------------
  logic [12:0]        lin_mul, lin_rem;
  logic [7:0]         s6_lin_d;
  logic signed [5:0]  f5_s;
  logic signed [16:0] den_s;
  logic signed [8:0]  l5_s;
  logic signed [27:0] s6_n_d;

  assign lin_mul  = 13'(s5_qe_q) * 13'(se);
  assign lin_rem  = s5_num_q - lin_mul;
  assign s6_lin_d = (lin_rem >= 13'(se)) ? s5_qe_q + 8'd1 : s5_qe_q;

  assign f5_s   = signed'({1'b0, s5_f_q});
  assign den_s  = signed'({1'b0, den});
  assign l5_s   = signed'({1'b0, s5_l_q});
  assign s6_n_d = 28'(den_s) * 28'(l5_s) + 28'(f5_s) * 28'(s5_v_q);

  logic [7:0]         s6_lin_q;
  logic signed [27:0] s6_n_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s6_lin_q <= s6_lin_d;
      s6_n_q   <= s6_n_d;
    end
  end

  // ---------------------------------------------------------------
  // Stage 7: clamp detection, cubic quotient estimate
  // ---------------------------------------------------------------
  logic        s7_neg_d, s7_sat_d;
  logic [23:0] s7_nlo_d;
  logic [50:0] cub_prod;
  logic [7:0]  s7_qc_d;

  assign s7_neg_d = s6_n_q[27];
  assign s7_sat_d = ~s6_n_q[27] & (s6_n_q[26:0] >= 27'({den, 8'b0}));
  assign s7_nlo_d = s6_n_q[23:0];
  assign cub_prod = 51'(s7_nlo_d) * 51'(rcp_cub);
  assign s7_qc_d  = cub_prod[usi_pkg::DenShift +: 8];

  logic [7:0]  s7_lin_q, s7_qc_q;
  logic        s7_neg_q, s7_sat_q;
  logic [23:0] s7_nlo_q;

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      s7_lin_q <= s6_lin_q;
      s7_qc_q  <= s7_qc_d;
      s7_neg_q <= s7_neg_d;
      s7_sat_q <= s7_sat_d;
      s7_nlo_q <= s7_nlo_d;
    end
  end

  // ---------------------------------------------------------------
  // Stage 8: correct cubic quotient, clamp, select mode
  // ---------------------------------------------------------------
  logic [23:0] cub_mul, cub_rem;
  logic [7:0]  cub_q, cub_pix, s8_pix_d;

  assign cub_mul = 24'(s7_qc_q) * 24'(den);
  assign cub_rem = s7_nlo_q - cub_mul;
  assign cub_q   = (cub_rem >= 24'(den)) ? s7_qc_q + 8'd1 : s7_qc_q;

  always_comb begin
    priority if (s7_neg_q) begin
      cub_pix = 8'd0;
    end else if (s7_sat_q) begin
      cub_pix = 8'hFF;
    end else begin
      cub_pix = cub_q;
    end
  end

  assign s8_pix_d = (mode_q == usi_pkg::ModeLinear) ? s7_lin_q : cub_pix;

  logic [7:0] s8_pix_q;

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      s8_pix_q <= s8_pix_d;
    end
  end

  assign pixel_value_o = s8_pix_q;

endmodule

`default_nettype wire

FILE: dv/usi_pixel_checker.sv
`default_nettype none

module usi_pixel_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_i,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [4:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [15:0] position_i,
  input  wire logic [7:0]  far_left_i,
  input  wire logic [7:0]  left_sample_i,
  input  wire logic [7:0]  right_sample_i,
  input  wire logic [7:0]  far_right_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [7:0]  pixel_value_i,
  output int               mismatch_count_o,
  output int               pixels_pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the block registers, tracked from write transactions
  logic [usi_pkg::ScaleW-1:0] scale_q;
  usi_pkg::mode_e             mode_q;
  logic [7:0]                 pixel_expected_q [$];
  int                         fails;

  // Linear or Catmull-Rom value at phase position mod scale, exact integers
  function automatic logic [7:0] interp_pixel(
    logic [usi_pkg::ScaleW-1:0] scale,
    usi_pkg::mode_e             mode,
    logic [15:0]                pos,
    logic [7:0]                 fl,
    logic [7:0]                 lft,
    logic [7:0]                 rgt,
    logic [7:0]                 fr
  );
    longint s, f, posv, p, l, r, q, a, b, c, s2, den, num, v;
    s    = scale;
    posv = pos;
    p    = fl;
    l    = lft;
    r    = rgt;
    q    = fr;
    // a zero scale behaves as one
    if (s == 0) begin
      s = 1;
    end
    f = posv % s;
    if (mode == usi_pkg::ModeLinear) begin
      v = ((s - f) * l + f * r) / s;
    end else begin
      a   = r - p;
      b   = 2 * p - 5 * l + 4 * r - q;
      c   = 3 * (l - r) + q - p;
      s2  = s * s;
      den = 2 * s2 * s;
      num = den * l + f * s2 * a + f * f * s * b + f * f * f * c;
      // signed division truncates toward zero, then clamp to a byte
      v = num / den;
      if (v < 0) begin
        v = 0;
      end else if (v > 255) begin
        v = 255;
      end
    end
    return v[7:0];
  endfunction

  // Track registers, predict on input transactions, compare on output ones
  always @(posedge clk_i or negedge rst_ni) begin : p_track
    logic [7:0] want;
    if (!rst_ni) begin
      scale_q = usi_pkg::ScaleRst;
      mode_q  = usi_pkg::ModeRst;
      pixel_expected_q.delete();
      fails = 0;
      mismatch_count_o <= 0;
      pixels_pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (usi_pkg::cfg_idx_e'(cfg_index_i))
          usi_pkg::CfgScale: begin
            scale_q = cfg_data_i;
          end
          usi_pkg::CfgMode: begin
            mode_q = usi_pkg::mode_e'(cfg_data_i[0]);
          end
          default: begin
          end
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (pixel_expected_q.size() == 0) begin
          $error("pixel_value: no transaction expected, actual %0d", pixel_value_i);
          fails++;
        end else begin
          want = pixel_expected_q.pop_front();
          if (pixel_value_i !== want) begin
            $error("pixel_value mismatch: expected %0d, actual %0d", want, pixel_value_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        pixel_expected_q.push_back(interp_pixel(scale_q, mode_q, position_i, far_left_i,
                                                left_sample_i, right_sample_i, far_right_i));
      end
      mismatch_count_o <= fails;
      pixels_pending_o <= pixel_expected_q.size();
    end
  end

endmodule

`default_nettype wire

FILE: dv/tb.sv
`default_nettype none

module tb;

  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i    = usi_pkg::CfgScale;
  logic [4:0]  cfg_data_i     = '0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [15:0] position_i     = '0;
  logic [7:0]  far_left_i     = '0;
  logic [7:0]  left_sample_i  = '0;
  logic [7:0]  right_sample_i = '0;
  logic [7:0]  far_right_i    = '0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [7:0]  pixel_value_o;

  int mismatch_count;
  int pixels_pending;

  // Idling controls: sender gap and receiver stall, in percent
  int idle_pct  = 0;
  int stall_pct = 0;
  // Each increment requests one long receiver hold-off
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  upscale_sample_interpolator u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .position_i     (position_i),
    .far_left_i     (far_left_i),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .far_right_i    (far_right_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_value_o  (pixel_value_o)
  );

  usi_pixel_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .position_i       (position_i),
    .far_left_i       (far_left_i),
    .left_sample_i    (left_sample_i),
    .right_sample_i   (right_sample_i),
    .far_right_i      (far_right_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .pixel_value_i    (pixel_value_o),
    .mismatch_count_o (mismatch_count),
    .pixels_pending_o (pixels_pending)
  );

  // Drive the receiver: long hold-off on request, random stalls otherwise
  always @(posedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Select one of the idling profiles
  task automatic set_idling(int profile);
    case (profile)
      0: begin
        idle_pct = 0;
        stall_pct <= 0;
      end
      1: begin
        idle_pct = 48;
        stall_pct <= 0;
      end
      2: begin
        idle_pct = 0;
        stall_pct <= 48;
      end
      default: begin
        idle_pct = 33;
        stall_pct <= 33;
      end
    endcase
  endtask

  // Wait until every predicted pixel has been received
  task automatic drain_pixels();
    do @(posedge clk_i); while (pixels_pending != 0);
  endtask

  // Drop the input, drain, then perform one register write transaction
  task automatic write_reg(usi_pkg::cfg_idx_e idx, logic [4:0] data);
    in_valid_i <= 1'b0;
    drain_pixels();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Offer one sample transaction after an optional random gap; valid stays high
  task automatic send_samples(logic [15:0] pos, logic [7:0] fl, logic [7:0] lft,
                              logic [7:0] rgt, logic [7:0] fr);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    position_i     <= pos;
    far_left_i     <= fl;
    left_sample_i  <= lft;
    right_sample_i <= rgt;
    far_right_i    <= fr;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Sample value biased toward the rails
  function automatic logic [7:0] rand_sample();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_random();
    send_samples(16'($urandom_range(65535)), rand_sample(), rand_sample(),
                 rand_sample(), rand_sample());
  endtask

  initial begin : p_stimulus
    logic [4:0] scale_sel;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_idling(0);

    // Reset settings: scale 2, cubic; rails, undershoot, overshoot, phase zero
    send_samples(16'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_samples(16'd1, 8'd255, 8'd255, 8'd255, 8'd255);
    send_samples(16'd65535, 8'd0, 8'd0, 8'd255, 8'd255);
    send_samples(16'd1, 8'd255, 8'd0, 8'd0, 8'd255);
    send_samples(16'd1, 8'd0, 8'd255, 8'd255, 8'd0);
    send_samples(16'd2, 8'd17, 8'd200, 8'd3, 8'd99);

    // Scale of zero behaves as one
    write_reg(usi_pkg::CfgScale, 5'd0);
    send_samples(16'd12345, 8'd9, 8'd77, 8'd180, 8'd240);
    send_samples(16'd65535, 8'd255, 8'd0, 8'd255, 8'd0);

    // Largest scale, above the meant range
    write_reg(usi_pkg::CfgScale, 5'd31);
    send_samples(16'd30, 8'd255, 8'd0, 8'd0, 8'd255);
    send_samples(16'd65535, 8'd0, 8'd255, 8'd255, 8'd0);
    send_samples(16'd15, 8'd0, 8'd0, 8'd255, 8'd255);

    // Linear mode at the largest scale
    write_reg(usi_pkg::CfgMode, usi_pkg::ModeLinear);
    send_samples(16'd30, 8'd0, 8'd0, 8'd255, 8'd0);
    send_samples(16'd1, 8'd0, 8'd255, 8'd0, 8'd0);
    send_samples(16'd31, 8'd255, 8'd123, 8'd45, 8'd255);

    write_reg(usi_pkg::CfgScale, 5'd16);
    send_samples(16'd15, 8'd0, 8'd255, 8'd255, 8'd0);
    send_samples(16'd8, 8'd255, 8'd0, 8'd255, 8'd255);

    write_reg(usi_pkg::CfgScale, 5'd1);
    send_samples(16'd65535, 8'd1, 8'd128, 8'd254, 8'd127);

    // Cubic at scale 16: undershoot and overshoot
    write_reg(usi_pkg::CfgMode, usi_pkg::ModeCubic);
    write_reg(usi_pkg::CfgScale, 5'd16);
    send_samples(16'd5, 8'd255, 8'd0, 8'd0, 8'd255);
    send_samples(16'd11, 8'd0, 8'd255, 8'd255, 8'd0);
    send_samples(16'd65535, 8'd255, 8'd255, 8'd255, 8'd255);

    // Random segments with random settings, rotating through the idling profiles
    for (int seg = 0; seg < 24; seg++) begin
      if ($urandom_range(3) != 0) begin
        scale_sel = 5'($urandom_range(16, 1));
      end else begin
        scale_sel = 5'($urandom_range(31));
      end
      write_reg(usi_pkg::CfgScale, scale_sel);
      write_reg(usi_pkg::CfgMode, usi_pkg::mode_e'($urandom_range(1)));
      set_idling(seg % 4);
      repeat (50) send_random();
    end

    // Hold the receiver off while the sender keeps offering transactions
    write_reg(usi_pkg::CfgMode, usi_pkg::ModeCubic);
    set_idling(0);
    hold_reqs <= hold_reqs + 1;
    repeat (40) send_random();

    in_valid_i <= 1'b0;
    drain_pixels();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Abort a hung run
  initial begin : p_timeout
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
design/usi_pkg.sv
design/upscale_sample_interpolator.sv
dv/usi_pixel_checker.sv
dv/tb.sv
